/* rtl/arpr_pkg.sv */
// ----------------------------------------------------------------------------
// arpr_pkg
// Shared types and protocol constants for the ARP request responder.
// ----------------------------------------------------------------------------
`default_nettype none

package arpr_pkg;

    localparam int unsigned FRAME_LEN   = 42;
    localparam int unsigned ETH_HDR_LEN = 14;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] HTYPE_ETH     = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  HLEN_ETH      = 8'h06;
    localparam logic [7:0]  PLEN_IPV4     = 8'h04;
    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [15:0] OP_REPLY      = 16'h0002;

    localparam logic [7:0] CFG_OWN_MAC = 8'd0;
    localparam logic [7:0] CFG_OWN_IP  = 8'd1;

    typedef struct packed {
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic [31:0] asked_ip;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

/* rtl/arpr_front.sv */
// ----------------------------------------------------------------------------
// arpr_front
// Frame parser: checks the ARP request header, captures the addresses and
// queues a reply job at the end of a matching frame.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_frame_byte,
    input  wire logic            i_frame_end,
    input  wire logic [31:0]     i_own_ip,
    output logic                 o_job_push,
    output arpr_pkg::t_job       o_job
);

    localparam logic [5:0] POS_ETYPE_HI = 6'(arpr_pkg::ETH_HDR_LEN - 2);
    localparam logic [5:0] POS_ETYPE_LO = 6'(arpr_pkg::ETH_HDR_LEN - 1);
    localparam logic [5:0] POS_HTYPE_HI = 6'(arpr_pkg::ETH_HDR_LEN + 0);
    localparam logic [5:0] POS_HTYPE_LO = 6'(arpr_pkg::ETH_HDR_LEN + 1);
    localparam logic [5:0] POS_PTYPE_HI = 6'(arpr_pkg::ETH_HDR_LEN + 2);
    localparam logic [5:0] POS_PTYPE_LO = 6'(arpr_pkg::ETH_HDR_LEN + 3);
    localparam logic [5:0] POS_OP_HI    = 6'(arpr_pkg::ETH_HDR_LEN + 6);
    localparam logic [5:0] POS_OP_LO    = 6'(arpr_pkg::ETH_HDR_LEN + 7);
    localparam logic [5:0] POS_SHA      = 6'(arpr_pkg::ETH_HDR_LEN + 8);
    localparam logic [5:0] POS_SPA      = 6'(arpr_pkg::ETH_HDR_LEN + 14);
    localparam logic [5:0] POS_THA      = 6'(arpr_pkg::ETH_HDR_LEN + 18);
    localparam logic [5:0] POS_TPA      = 6'(arpr_pkg::ETH_HDR_LEN + 24);
    localparam logic [5:0] POS_LAST     = 6'(arpr_pkg::FRAME_LEN - 1);
    localparam logic [5:0] POS_MAX      = 6'd63;

    logic [5:0]  r_pos;
    logic        r_pass;
    logic [47:0] r_peer_mac;
    logic [31:0] r_peer_ip;
    logic [31:0] r_asked_ip;

    logic [47:0] n_peer_mac;
    logic [31:0] n_peer_ip;
    logic [31:0] n_asked_ip;
    logic        n_pass;
    logic        chk_en;
    logic [7:0]  chk_val;

    always_comb begin
        chk_en  = 1'b1;
        chk_val = 8'h00;
        unique case (r_pos)
            POS_ETYPE_HI: chk_val = arpr_pkg::ETHERTYPE_ARP[15:8];
            POS_ETYPE_LO: chk_val = arpr_pkg::ETHERTYPE_ARP[7:0];
            POS_HTYPE_HI: chk_val = arpr_pkg::HTYPE_ETH[15:8];
            POS_HTYPE_LO: chk_val = arpr_pkg::HTYPE_ETH[7:0];
            POS_PTYPE_HI: chk_val = arpr_pkg::PTYPE_IPV4[15:8];
            POS_PTYPE_LO: chk_val = arpr_pkg::PTYPE_IPV4[7:0];
            POS_OP_HI:    chk_val = arpr_pkg::OP_REQUEST[15:8];
            POS_OP_LO:    chk_val = arpr_pkg::OP_REQUEST[7:0];
            default:      chk_en  = 1'b0;
        endcase
    end

    always_comb begin
        n_pass     = r_pass && !(chk_en && (i_frame_byte != chk_val));
        n_peer_mac = r_peer_mac;
        n_peer_ip  = r_peer_ip;
        n_asked_ip = r_asked_ip;
        if (r_pos >= POS_SHA && r_pos < POS_SPA) begin
            n_peer_mac = {r_peer_mac[39:0], i_frame_byte};
        end
        if (r_pos >= POS_SPA && r_pos < POS_THA) begin
            n_peer_ip = {r_peer_ip[23:0], i_frame_byte};
        end
        if (r_pos >= POS_TPA && r_pos <= POS_LAST) begin
            n_asked_ip = {r_asked_ip[23:0], i_frame_byte};
        end
    end

    assign o_job_push = i_accept && i_frame_end && (r_pos >= POS_LAST) && n_pass
                        && (n_asked_ip == i_own_ip);
    assign o_job      = {n_peer_mac, n_peer_ip, n_asked_ip};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_pass <= 1'b1;
        end else if (i_accept) begin
            if (i_frame_end) begin
                r_pos  <= '0;
                r_pass <= 1'b1;
            end else begin
                r_pass <= n_pass;
                if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_peer_mac <= n_peer_mac;
            r_peer_ip  <= n_peer_ip;
            r_asked_ip <= n_asked_ip;
        end
    end

endmodule

`default_nettype wire

/* rtl/arpr_jobq.sv */
// ----------------------------------------------------------------------------
// arpr_jobq
// Short register queue of reply jobs between parser and reply generator.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_jobq #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire arpr_pkg::t_job  i_job,
    input  wire logic            i_pop,
    output arpr_pkg::t_job       o_head,
    output arpr_pkg::t_q_stat    o_stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

    arpr_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_stat  = {(r_cnt == CW'(DEPTH)), (r_cnt == CW'(0))};
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

/* rtl/arpr_back.sv */
// ----------------------------------------------------------------------------
// arpr_back
// Reply generator: streams the 42-byte ARP reply for the head job into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire arpr_pkg::t_job  i_job,
    input  wire logic            i_job_valid,
    input  wire logic [47:0]     i_own_mac,
    input  wire logic            i_pop,
    output logic                 o_job_pop,
    output logic                 o_empty,
    output logic [7:0]           o_reply_byte,
    output logic                 o_reply_last
);

    localparam logic [5:0] IDX_LAST = 6'(arpr_pkg::FRAME_LEN - 1);
    localparam int unsigned FW = 8 * arpr_pkg::FRAME_LEN;

    logic [5:0]    r_idx;
    logic          r_valid;
    logic [7:0]    r_byte;
    logic          r_last;
    logic          adv;
    logic          emit;
    logic [5:0]    sel;
    logic [FW-1:0] frame;

    assign frame = {i_job.peer_mac, i_own_mac, arpr_pkg::ETHERTYPE_ARP,
                    arpr_pkg::HTYPE_ETH, arpr_pkg::PTYPE_IPV4,
                    arpr_pkg::HLEN_ETH, arpr_pkg::PLEN_IPV4, arpr_pkg::OP_REPLY,
                    i_own_mac, i_job.asked_ip, i_job.peer_mac, i_job.peer_ip};

    assign sel       = IDX_LAST - r_idx;
    assign adv       = !r_valid || i_pop;
    assign emit      = adv && i_job_valid;
    assign o_job_pop = emit && (r_idx == IDX_LAST);

    assign o_empty      = !r_valid;
    assign o_reply_byte = r_byte;
    assign o_reply_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_valid <= i_job_valid;
            end
            if (emit) begin
                r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= frame[{sel, 3'b000} +: 8];
            r_last <= (r_idx == IDX_LAST);
        end
    end

endmodule

`default_nettype wire

/* rtl/arp_request_responder_core.sv */
// ----------------------------------------------------------------------------
// arp_request_responder_core
// ARP request responder: parses received Ethernet frames and answers ARP
// requests for the configured IPv4 address with a 42-byte reply.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per clock while full is low. A matching request
// queues one reply job, and the reply generator sends its 42 bytes one per
// clock through the result port while pop is high. Input stalls (full high)
// only while the reply job queue holds JOB_DEPTH jobs, set by the generator
// draining one job per 42 emitted bytes.
`default_nettype none

module arp_request_responder_core #(
    parameter int unsigned JOB_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_frame_byte,
    input  wire logic        i_frame_end,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_reply_byte,
    output logic             o_reply_last
);

    logic [47:0]       r_own_mac;
    logic [31:0]       r_own_ip;
    logic              accept;
    logic              job_push;
    logic              job_pop;
    arpr_pkg::t_job    job_in;
    arpr_pkg::t_job    job_head;
    arpr_pkg::t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == arpr_pkg::CFG_OWN_MAC) begin
                r_own_mac <= i_cfg_data;
            end else if (i_cfg_idx == arpr_pkg::CFG_OWN_IP) begin
                r_own_ip <= i_cfg_data[31:0];
            end
        end
    end

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    arpr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_frame_byte (i_frame_byte),
        .i_frame_end  (i_frame_end),
        .i_own_ip     (r_own_ip),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    arpr_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_head  (job_head),
        .o_stat  (q_stat)
    );

    arpr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job_head),
        .i_job_valid  (!q_stat.empty),
        .i_own_mac    (r_own_mac),
        .i_pop        (pop),
        .o_job_pop    (job_pop),
        .o_empty      (empty),
        .o_reply_byte (o_reply_byte),
        .o_reply_last (o_reply_last)
    );

endmodule

`default_nettype wire

/* test/arp_reply_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_reply_check
// Watches the frame, register and reply ports of the ARP responder. It keeps
// its own copy of the parser state and the station address and queues the
// reply bytes that each frame should cause. Each popped reply byte is compared
// with the oldest of these, and the mismatch count goes back to the top.
// ----------------------------------------------------------------------------
module arp_reply_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_frame_byte,
    input  logic       i_frame_end,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_reply_byte,
    input  logic       i_reply_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    localparam logic [79:0] REQ_HDR = {arpr_pkg::ETHERTYPE_ARP, arpr_pkg::HTYPE_ETH,
        arpr_pkg::PTYPE_IPV4, arpr_pkg::HLEN_ETH, arpr_pkg::PLEN_IPV4, arpr_pkg::OP_REQUEST};
    localparam logic [79:0] REPLY_HDR = {arpr_pkg::ETHERTYPE_ARP, arpr_pkg::HTYPE_ETH,
        arpr_pkg::PTYPE_IPV4, arpr_pkg::HLEN_ETH, arpr_pkg::PLEN_IPV4, arpr_pkg::OP_REPLY};
    localparam int HDR_AT      = 12;
    localparam int HLEN_AT     = 18;
    localparam int PLEN_AT     = 19;
    localparam int PEER_MAC_AT = 22;
    localparam int PEER_IP_AT  = 28;
    localparam int TGT_MAC_AT  = 32;
    localparam int ASKED_IP_AT = 38;
    localparam int ARP_LEN     = int'(arpr_pkg::FRAME_LEN);

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_reply_beat;

    t_reply_beat replies_due[$];

    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [5:0]  frame_pos;
    logic        hdr_ok;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic [31:0] asked_ip;
    int          fails = 0;
    int          checked = 0;

    function automatic logic [7:0] reply_byte_at(int i);
        if (i < 6) return peer_mac[47 - 8*i -: 8];
        if (i < HDR_AT) return own_mac[47 - 8*(i - 6) -: 8];
        if (i < PEER_MAC_AT) return REPLY_HDR[79 - 8*(i - HDR_AT) -: 8];
        if (i < PEER_IP_AT) return own_mac[47 - 8*(i - PEER_MAC_AT) -: 8];
        if (i < TGT_MAC_AT) return asked_ip[31 - 8*(i - PEER_IP_AT) -: 8];
        if (i < ASKED_IP_AT) return peer_mac[47 - 8*(i - TGT_MAC_AT) -: 8];
        return peer_ip[31 - 8*(i - ASKED_IP_AT) -: 8];
    endfunction

    task automatic take_frame_byte(input logic [7:0] b, input logic e);
        int          pos;
        t_reply_beat beat;
        pos = frame_pos;
        if (pos >= HDR_AT && pos < PEER_MAC_AT && pos != HLEN_AT && pos != PLEN_AT &&
            b != REQ_HDR[79 - 8*(pos - HDR_AT) -: 8]) begin
            hdr_ok = 1'b0;
        end
        if (pos >= PEER_MAC_AT && pos < PEER_IP_AT) begin
            peer_mac = {peer_mac[39:0], b};
        end else if (pos >= PEER_IP_AT && pos < TGT_MAC_AT) begin
            peer_ip = {peer_ip[23:0], b};
        end else if (pos >= ASKED_IP_AT && pos < ARP_LEN) begin
            asked_ip = {asked_ip[23:0], b};
        end
        if (e) begin
            if (pos >= ARP_LEN - 1 && hdr_ok && asked_ip == own_ip) begin
                for (int i = 0; i < ARP_LEN; i++) begin
                    beat.last = (i == ARP_LEN - 1);
                    beat.data = reply_byte_at(i);
                    replies_due.push_back(beat);
                end
            end
            frame_pos = '0;
            hdr_ok    = 1'b1;
        end else if (frame_pos != '1) begin
            frame_pos = frame_pos + 6'd1;
        end
    endtask

    task automatic check_reply(input logic [7:0] b, input logic l);
        t_reply_beat due;
        checked++;
        if (replies_due.size() == 0) begin
            fails++;
            $display("%0t: reply byte: expected none, got %02h (last %0b)", $time, b, l);
        end else begin
            due = replies_due.pop_front();
            if (b !== due.data) begin
                fails++;
                $display("%0t: reply byte: expected %02h, got %02h", $time, due.data, b);
            end
            if (l !== due.last) begin
                fails++;
                $display("%0t: reply last: expected %0b, got %0b", $time, due.last, l);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            own_mac   = '0;
            own_ip    = '0;
            frame_pos = '0;
            hdr_ok    = 1'b1;
            peer_mac  = '0;
            peer_ip   = '0;
            asked_ip  = '0;
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    arpr_pkg::CFG_OWN_MAC: own_mac = i_cfg_data;
                    arpr_pkg::CFG_OWN_IP:  own_ip  = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) take_frame_byte(i_frame_byte, i_frame_end);
            if (i_pop && !i_empty) check_reply(i_reply_byte, i_reply_last);
        end
        o_fail_count <= fails;
        o_pending    <= replies_due.size();
        o_checked    <= checked;
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds Ethernet frames byte by byte into the ARP responder: matching
// requests, wrong targets, broken header bytes, short, long and noise frames,
// under several station addresses and sender/receiver idling mixes. Checking
// is done by arp_reply_check; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [79:0] REQ_HDR = {arpr_pkg::ETHERTYPE_ARP, arpr_pkg::HTYPE_ETH,
        arpr_pkg::PTYPE_IPV4, arpr_pkg::HLEN_ETH, arpr_pkg::PLEN_IPV4, arpr_pkg::OP_REQUEST};
    localparam logic [7:0] CFG_SPARE_IDX = 8'd2;
    localparam int HDR_AT        = 12;
    localparam int HLEN_AT       = 18;
    localparam int PLEN_AT       = 19;
    localparam int PEER_MAC_AT   = 22;
    localparam int PEER_IP_AT    = 28;
    localparam int TGT_MAC_AT    = 32;
    localparam int ASKED_IP_AT   = 38;
    localparam int ARP_LEN       = int'(arpr_pkg::FRAME_LEN);
    localparam int RESET_CYCLES  = 9;
    localparam int PHASE_ITEMS   = 40;
    localparam int FILL_TAIL_LEN = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_idx = '0;
    logic [47:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  frame_byte = '0;
    logic        frame_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  reply_byte;
    logic        reply_last;

    int fail_count;
    int pending;
    int checked;

    logic [7:0]  frame[$];
    logic [31:0] own_ip_now = '0;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    int          frames_sent = 0;
    int          bytes_sent = 0;
    int          cfg_writes = 0;

    arp_request_responder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .push         (push),
        .full         (full),
        .i_frame_byte (frame_byte),
        .i_frame_end  (frame_end),
        .empty        (empty),
        .pop          (pop),
        .o_reply_byte (reply_byte),
        .o_reply_last (reply_last)
    );

    arp_reply_check u_reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_frame_byte (frame_byte),
        .i_frame_end  (frame_end),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_reply_byte (reply_byte),
        .i_reply_last (reply_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    initial begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [47:0] random_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    task automatic send_item(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        frame_byte <= b;
        frame_end  <= e;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++) send_item(frame[i], i == frame.size() - 1);
        frames_sent++;
    endtask

    task automatic build_request(input logic [47:0] smac, input logic [31:0] sip,
                                 input logic [31:0] tip, input int len);
        frame.delete();
        for (int i = 0; i < len; i++) begin
            if (i < 6) frame.push_back(8'hff);
            else if (i < HDR_AT) frame.push_back($urandom_range(255));
            else if (i < PEER_MAC_AT) frame.push_back(REQ_HDR[79 - 8*(i - HDR_AT) -: 8]);
            else if (i < PEER_IP_AT) frame.push_back(smac[47 - 8*(i - PEER_MAC_AT) -: 8]);
            else if (i < TGT_MAC_AT) frame.push_back(sip[31 - 8*(i - PEER_IP_AT) -: 8]);
            else if (i < ASKED_IP_AT) frame.push_back($urandom_range(255));
            else if (i < ARP_LEN) frame.push_back(tip[31 - 8*(i - ASKED_IP_AT) -: 8]);
            else frame.push_back($urandom_range(255));
        end
    endtask

    // lowers push, waits for every queued reply byte, then lets the core settle
    task automatic drain_replies();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [47:0] val);
        cfg_idx  <= idx;
        cfg_data <= val;
        cfg_we   <= 1'b1;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == arpr_pkg::CFG_OWN_IP) own_ip_now = val[31:0];
        cfg_writes++;
    endtask

    task automatic send_random_frame();
        int          kind;
        int          len;
        int          p;
        logic [31:0] tip;
        logic [7:0]  flip;
        kind = $urandom_range(99);
        len  = ($urandom_range(3) == 0) ? ARP_LEN + $urandom_range(30, 1) : ARP_LEN;
        tip  = own_ip_now;
        if (kind >= 55 && kind < 65) tip = $urandom;
        if (kind >= 80 && kind < 88) len = $urandom_range(ARP_LEN - 1, 1);
        if (kind >= 94) drain_replies();
        build_request(random_mac(), $urandom, tip, len);
        if ($urandom_range(7) == 0 && len > PLEN_AT) begin
            frame[HLEN_AT] = $urandom_range(255);
            frame[PLEN_AT] = $urandom_range(255);
        end
        if (kind >= 65 && kind < 80) begin
            p = HDR_AT + $urandom_range(7);
            if (p >= HLEN_AT) p += 2;
            flip = 8'h01 << $urandom_range(7);
            frame[p] = frame[p] ^ flip;
        end
        if (kind >= 88 && kind < 94) begin
            frame.delete();
            repeat ($urandom_range(70, 1)) frame.push_back($urandom_range(255));
        end
        send_frame();
    endtask

    initial begin
        int phase_start;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset addresses are zero; two replies against a slow receiver fill
        // the job queue and the short frame after them waits on full
        pop_stall_pct = 84;
        repeat (2) begin
            build_request(random_mac(), $urandom, 32'h0, ARP_LEN);
            send_frame();
        end
        build_request(random_mac(), $urandom, 32'h0, FILL_TAIL_LEN);
        send_frame();
        drain_replies();
        pop_stall_pct = 0;

        for (int ph = 0; ph < 4; ph++) begin
            drain_replies();
            if (ph == 0) begin
                write_reg(arpr_pkg::CFG_OWN_MAC, 48'hffff_ffff_ffff);
                write_reg(arpr_pkg::CFG_OWN_IP, 48'hffff_ffff);
                send_idle_pct = 0;
                pop_stall_pct = 0;
            end else if (ph == 3) begin
                write_reg(arpr_pkg::CFG_OWN_MAC, 48'h0);
                write_reg(arpr_pkg::CFG_OWN_IP, 48'h0);
                send_idle_pct = 24;
                pop_stall_pct = 24;
            end else begin
                write_reg(arpr_pkg::CFG_OWN_MAC, random_mac());
                write_reg(arpr_pkg::CFG_OWN_IP, {16'h0, $urandom});
                write_reg(CFG_SPARE_IDX, {16'hffff, $urandom});
                send_idle_pct = (ph == 1) ? 84 : 0;
                pop_stall_pct = (ph == 2) ? 84 : 0;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS) send_random_frame();
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d frames (%0d bytes) over four idle/stall mixes, %0d register writes;",
                 frames_sent, bytes_sent, cfg_writes);
        $display("%0d reply bytes compared, %0d mismatches.", checked, fail_count);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

/* arp_request_responder_core.f */
rtl/arpr_pkg.sv
rtl/arpr_front.sv
rtl/arpr_jobq.sv
rtl/arpr_back.sv
rtl/arp_request_responder_core.sv
test/arp_reply_check.sv
test/testbench.sv
